### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the dated rate table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

### hdl/drfl_pkg.sv
// ----------------------------------------------------------------------------
// Dated rate table package
// Types, constants and the month length table shared by the rate table RTL.
// ----------------------------------------------------------------------------
package drfl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 7;
    localparam int DAY_W   = 7;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
    localparam int RATE_W  = 40;
    localparam int AMT_W   = 32;
    localparam int MAXV_W  = 31;
    localparam int PROD_W  = 50;
    localparam int FRAC_W  = 16;

    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [MAXV_W-1:0]  MAX_VALUE_RESET = 31'd65536000;
    // floor(year / 25) = (year * 5243) >> 17 for every 14-bit year.
    localparam logic [MUL_B_W-1:0] DIV25_RECIP     = 24'd5243;
    localparam int                 DIV25_SHIFT     = 17;
    localparam int                 QUOT_W          = 10;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 7'd12;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_DATE   = 3'd1,
        ST_NEGATIVE   = 3'd2,
        ST_TOO_LARGE  = 3'd3,
        ST_NO_EARLIER = 3'd4,
        ST_EMPTY      = 3'd5,
        ST_FULL       = 3'd6
    } status_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic                      mode;
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic [RATE_W-1:0]         entry_rate;
        logic signed [AMT_W-1:0]   amount;
    } in_req_t;

    typedef struct packed {
        status_t                   status;
        logic [RATE_W-1:0]         found_rate;
        logic [PROD_W-1:0]         product;
    } out_req_t;

    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] days;
        case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
            4'd2:                                       days = 5'd28;
            default:                                    days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

### hdl/drfl_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered 31 x 24 bit unsigned multiplier reused by the sequencer.
// ----------------------------------------------------------------------------
module drfl_mul (
    input  logic                          aclk,
    input  logic [drfl_pkg::MUL_A_W-1:0]  op_a,
    input  logic [drfl_pkg::MUL_B_W-1:0]  op_b,
    output logic [drfl_pkg::MUL_P_W-1:0]  mul_p
);
    import drfl_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign mul_p = prod_reg;

endmodule

### hdl/dated_rate_floor_lookup.sv
// ----------------------------------------------------------------------------
// Dated rate floor lookup
// Table of dated rates with insert/overwrite and greatest-key-not-after query.
// ----------------------------------------------------------------------------
// The scan reads one stored key and rate per cycle from the key and rate memories,
// so the time from acceptance to result grows with entry_count. One request is in
// work at a time, but the next request is accepted while a finished result waits
// on m_ready.
`include "assert_macros.svh"

module dated_rate_floor_lookup (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  drfl_pkg::in_req_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output drfl_pkg::out_req_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [drfl_pkg::MAXV_W-1:0]    cfg_wr_data
);
    import drfl_pkg::*;

    logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
    logic [RATE_W-1:0] rate_mem [TABLE_DEPTH];

    fsm_state_t         state_reg, state_next;
    in_req_t            in_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [KEY_W-1:0]   rd_key_reg;
    logic [RATE_W-1:0]  rd_rate_reg;
    logic               found_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [RATE_W-1:0]  best_rate_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    status_t            status_reg;
    logic [MUL_A_W-1:0] lo_reg;
    logic [PROD_W-1:0]  product_reg;
    logic               m_valid_reg;
    out_req_t           m_data_reg;
    logic [MAXV_W-1:0]  max_value_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic [KEY_W-1:0]   query_key;
    logic               issuing;
    logic               scan_done;
    logic               table_full;
    logic [QUOT_W-1:0]  quot25;
    logic [YEAR_W-1:0]  back25;
    logic               leap;
    logic [4:0]         day_limit;
    logic               date_ok;
    status_t            check_status;
    logic               mem_we;
    logic               key_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [MUL_P_W:0]   prod_sum;
    logic               out_load;

    drfl_mul u_mul (
        .aclk  (aclk),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .mul_p (mul_p)
    );

    assign query_key  = {in_reg.year, in_reg.month, in_reg.day};
    assign issuing    = (scan_idx_reg < count_reg);
    assign scan_done  = !issuing && !cmp_vld_reg;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    // Leap test: divisible by 4 and not by 25, or divisible by 16 and by 25.
    assign quot25    = mul_p[DIV25_SHIFT +: QUOT_W];
    assign back25    = YEAR_W'({quot25, 4'b0000}) + YEAR_W'({quot25, 3'b000}) + YEAR_W'(quot25);
    assign leap      = (in_reg.year[1:0] == 2'b00)
                       && ((back25 != in_reg.year) || (in_reg.year[3:0] == 4'b0000));
    assign day_limit = month_days(in_reg.month[3:0])
                       + 5'((in_reg.month == MONTH_FEB) && leap);
    assign date_ok   = (in_reg.month != '0) && (in_reg.month <= MONTH_DEC)
                       && (in_reg.day != '0) && (in_reg.day <= DAY_W'(day_limit));

    always_comb begin
        if (count_reg == '0) begin
            check_status = ST_EMPTY;
        end else if (!date_ok) begin
            check_status = ST_BAD_DATE;
        end else if (in_reg.amount[AMT_W-1]) begin
            check_status = ST_NEGATIVE;
        end else if (in_reg.amount[MAXV_W-1:0] > max_value_reg) begin
            check_status = ST_TOO_LARGE;
        end else begin
            check_status = ST_OK;
        end
    end

    assign prod_sum = {1'b0, mul_p} + (MUL_P_W + 1)'(lo_reg);
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_a      = in_reg.amount[MUL_A_W-1:0];
        mul_b      = best_rate_reg[RATE_W-1:FRAC_W];
        mem_we     = 1'b0;
        key_we     = 1'b0;
        wr_addr    = count_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                mul_a      = MUL_A_W'(in_reg.year);
                mul_b      = DIV25_RECIP;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (in_reg.mode == MODE_LOAD) begin
                    state_next = S_SCAN;
                end else if (check_status != ST_OK) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    if (in_reg.mode == MODE_LOAD) begin
                        state_next = S_WRITE;
                    end else if (found_reg) begin
                        state_next = S_MUL_LO;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WRITE: begin
                if (found_reg) begin
                    mem_we  = 1'b1;
                    wr_addr = match_idx_reg;
                end else if (!table_full) begin
                    mem_we = 1'b1;
                    key_we = 1'b1;
                end
                state_next = S_DONE;
            end
            S_MUL_LO: begin
                mul_b      = MUL_B_W'(best_rate_reg[FRAC_W-1:0]);
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                state_next = S_SUM;
            end
            S_SUM: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            max_value_reg <= MAX_VALUE_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_value_reg <= cfg_wr_data;
            end
            cmp_vld_reg <= (state_reg == S_SCAN) && issuing;
            if (key_we) begin
                count_reg <= count_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_key_reg  <= key_mem[scan_idx_reg[IDX_W-1:0]];
        rd_rate_reg <= rate_mem[scan_idx_reg[IDX_W-1:0]];
        if (mem_we) begin
            rate_mem[wr_addr] <= in_reg.entry_rate;
        end
        if (key_we) begin
            key_mem[wr_addr] <= query_key;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        if (out_load) begin
            m_data_reg.status     <= status_reg;
            m_data_reg.found_rate <= ((status_reg == ST_OK) && (in_reg.mode == MODE_QUERY))
                                     ? best_rate_reg : '0;
            m_data_reg.product    <= product_reg;
        end
        case (state_reg)
            S_IDLE: begin
                in_reg       <= s_data;
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
                status_reg   <= ST_OK;
                product_reg  <= '0;
            end
            S_CHECK: begin
                if (in_reg.mode == MODE_QUERY) begin
                    status_reg <= check_status;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (cmp_vld_reg) begin
                    if (in_reg.mode == MODE_LOAD) begin
                        if (rd_key_reg == query_key) begin
                            found_reg     <= 1'b1;
                            match_idx_reg <= cmp_idx_reg;
                        end
                    end else if ((rd_key_reg <= query_key)
                                 && (!found_reg || (rd_key_reg > best_key_reg))) begin
                        found_reg     <= 1'b1;
                        best_key_reg  <= rd_key_reg;
                        best_rate_reg <= rd_rate_reg;
                    end
                end
                if (scan_done && (in_reg.mode == MODE_QUERY) && !found_reg) begin
                    status_reg <= ST_NO_EARLIER;
                end
            end
            S_WRITE: begin
                if (!found_reg && table_full) begin
                    status_reg <= ST_FULL;
                end
            end
            S_MUL_HI: begin
                lo_reg <= mul_p[FRAC_W +: MUL_A_W];
            end
            S_SUM: begin
                if (prod_sum[MUL_P_W:PROD_W] != '0) begin
                    product_reg <= '1;
                end else begin
                    product_reg <= prod_sum[PROD_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_PROP(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
    `ASSERT_PROP(a_accept_decode, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == S_DECODE), "accepted request did not start decoding")
    `ASSERT_PROP(a_count_step, aclk, aresetn, 1'b1 |=> ((count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1)), "entry count moved by more than one")
    `ASSERT_PROP(a_error_zero, aclk, aresetn, (m_valid && (m_data.status != ST_OK)) |-> ((m_data.found_rate == '0) && (m_data.product == '0)), "error result carries a rate or product")
    `ASSERT_NEVER(a_write_busy_out, aclk, aresetn, out_load && (state_reg != S_DONE), "result loaded outside the done state")

endmodule
